// ===== src/irf_pkg.sv =====
// Shared types, constants and helpers for the IPv4 route/forward core.
`timescale 1ns / 1ps
package irf_pkg;

    localparam int ROUTE_ENTRIES_DEF    = 64;
    localparam int MAX_HEADER_WORDS_DEF = 15;

    localparam int WORD_IDX_W = 4;
    localparam int SUM_W      = 21;
    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 64;

    localparam logic [WORD_IDX_W-1:0] TTL_WORD  = 4'd2;
    localparam logic [WORD_IDX_W-1:0] DEST_WORD = 4'd4;

    localparam logic ACT_ADD_ROUTE = 1'b0;
    localparam logic ACT_HDR_WORD  = 1'b1;

    typedef enum logic [2:0] {
        V_FORWARD = 3'd0,
        V_LOCAL   = 3'd1,
        V_TTL     = 3'd2,
        V_NOROUTE = 3'd3,
        V_STORED  = 3'd4,
        V_FULL    = 3'd5
    } verdict_t;

    // route write broadcast to the cell row
    typedef struct packed {
        logic        en;
        logic [31:0] mask;
        logic [31:0] prefix;   // already masked
        logic [31:0] gateway;
    } route_wr_t;

    // lookup request moving down the cell row
    typedef struct packed {
        logic        valid;
        logic        found;
        logic [31:0] dest;
        logic [31:0] hop;
    } search_tok_t;

    function automatic logic [31:0] mask_of(input logic [5:0] len);
        logic [31:0] m;
        if (len == 6'd0)
        begin
            m = 32'h0000_0000;
        end
        else if (len >= 6'd32)
        begin
            m = 32'hFFFF_FFFF;
        end
        else
        begin
            m = ~(32'hFFFF_FFFF >> len);
        end
        return m;
    endfunction

endpackage

// ===== src/irf_cell.sv =====
// One route table cell: holds one entry and checks the passing lookup request.
`timescale 1ns / 1ps
module irf_cell #(
    parameter int CNT_W = 7,
    parameter int INDEX = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic [CNT_W-1:0]   count,
    input  irf_pkg::route_wr_t wr,
    input  irf_pkg::search_tok_t tok_in,
    output irf_pkg::search_tok_t tok_out
);
    import irf_pkg::*;

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

    logic [31:0] mask_reg;
    logic [31:0] prefix_reg;
    logic [31:0] gateway_reg;
    search_tok_t tok_reg;
    search_tok_t tok_next;
    logic        hit;

    always_ff @(posedge clk)
    begin
        if (wr.en && (count == MY_IDX))
        begin
            mask_reg    <= wr.mask;
            prefix_reg  <= wr.prefix;
            gateway_reg <= wr.gateway;
        end
    end

    // only entries below the fill count take part
    assign hit = tok_in.valid && !tok_in.found && (MY_IDX < count)
                 && (prefix_reg == (tok_in.dest & mask_reg));

    always_comb
    begin
        tok_next = tok_in;
        if (hit)
        begin
            tok_next.found = 1'b1;
            tok_next.hop   = gateway_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else if (adv)
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== src/ipv4_route_forward_core.sv =====
// IPv4 route/forward core: header accumulation, route cell row, result register.
// Header words and route adds: one request per cycle while no lookup runs and the
// output register is free; an add, a TTL discard or a local verdict reaches the output
// register in the cycle after acceptance. Forward / no-route: input stalls while the
// lookup walks the cell row one cell per cycle, held at the end if the output is full.
// Reset (async, active low) empties the table and the packet state; local_address = 0.
`timescale 1ns / 1ps
module ipv4_route_forward_core #(
    parameter int ROUTE_ENTRIES    = irf_pkg::ROUTE_ENTRIES_DEF,
    parameter int MAX_HEADER_WORDS = irf_pkg::MAX_HEADER_WORDS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [31:0]                    cfg_wr_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // route_prefix[31:0], route_prefix_len[37:32], route_gateway[69:38],
    // header_word[101:70], zero fill
    input  logic [irf_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                           s_axis_tuser,   // action
    input  logic                           s_axis_tlast,   // word_last
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // verdict[2:0], out_next_hop[34:3], out_ttl[42:35], out_checksum[58:43], zero fill
    output logic [irf_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import irf_pkg::*;

    localparam int CNT_W = $clog2(ROUTE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(ROUTE_ENTRIES);
    localparam logic [WORD_IDX_W-1:0] IDX_MAX = WORD_IDX_W'(MAX_HEADER_WORDS);

    logic [31:0]           local_addr_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [WORD_IDX_W-1:0] widx_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [7:0]            ttl_reg;
    logic [31:0]           dest_reg;
    logic                  busy_reg;
    logic [7:0]            pend_ttl_reg;
    logic [15:0]           pend_ck_reg;
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic [31:0] in_prefix;
    logic [5:0]  in_len;
    logic [31:0] in_gateway;
    logic [31:0] in_word;
    logic        accept;
    logic        add_acc;
    logic        hdr_acc;
    logic        last_acc;
    logic        table_full;
    logic        capture;
    logic [31:0] w_mod;
    logic [7:0]  ttl_next;
    logic [31:0] dest_next;
    logic [SUM_W-1:0] sum_next;
    logic [16:0] fold1;
    logic [16:0] fold2;
    logic [15:0] ck_final;
    logic        search_start;
    logic        out_free;
    logic        adv;
    logic        chain_done;
    logic        imm_load;
    verdict_t    imm_verdict;
    route_wr_t   wr;
    logic [31:0] wr_mask;
    search_tok_t tok [ROUTE_ENTRIES+1];
    logic [ROUTE_ENTRIES-1:0] tok_valids;

    assign in_prefix  = s_axis_tdata[31:0];
    assign in_len     = s_axis_tdata[37:32];
    assign in_gateway = s_axis_tdata[69:38];
    assign in_word    = s_axis_tdata[101:70];

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !busy_reg && out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign add_acc       = accept && (s_axis_tuser == ACT_ADD_ROUTE);
    assign hdr_acc       = accept && (s_axis_tuser == ACT_HDR_WORD);
    assign last_acc      = hdr_acc && s_axis_tlast;
    assign table_full    = (count_reg >= CNT_MAX);

    // header word update, including the word taken this cycle
    assign capture = (widx_reg < IDX_MAX);

    always_comb
    begin
        ttl_next  = ttl_reg;
        dest_next = dest_reg;
        sum_next  = sum_reg;
        w_mod     = in_word;
        if (capture)
        begin
            if (widx_reg == TTL_WORD)
            begin
                ttl_next = in_word[31:24];
                w_mod    = {in_word[31:24] - 8'd1, in_word[23:16], 16'h0000};
            end
            else if (widx_reg == DEST_WORD)
            begin
                dest_next = in_word;
            end
            sum_next = sum_reg + SUM_W'(w_mod[31:16]) + SUM_W'(w_mod[15:0]);
        end
    end

    // ones-complement fold applied twice
    assign fold1    = 17'(sum_next[15:0]) + 17'(sum_next[SUM_W-1:16]);
    assign fold2    = 17'(fold1[15:0]) + 17'(fold1[16]);
    assign ck_final = ~fold2[15:0];

    always_comb
    begin
        imm_load    = 1'b0;
        imm_verdict = V_STORED;
        if (add_acc)
        begin
            imm_load    = 1'b1;
            imm_verdict = table_full ? V_FULL : V_STORED;
        end
        else if (last_acc)
        begin
            if (ttl_next == 8'd0)
            begin
                imm_load    = 1'b1;
                imm_verdict = V_TTL;
            end
            else if (dest_next == local_addr_reg)
            begin
                imm_load    = 1'b1;
                imm_verdict = V_LOCAL;
            end
        end
    end

    assign search_start = last_acc && !imm_load;

    assign wr_mask    = mask_of(in_len);
    assign wr.en      = add_acc && !table_full;
    assign wr.mask    = wr_mask;
    assign wr.prefix  = in_prefix & wr_mask;
    assign wr.gateway = in_gateway;

    // cell row
    assign chain_done = tok[ROUTE_ENTRIES].valid;
    assign adv        = !chain_done || out_free;

    assign tok[0].valid = search_start;
    assign tok[0].found = 1'b0;
    assign tok[0].dest  = dest_next;
    assign tok[0].hop   = 32'h0000_0000;

    for (genvar i = 0; i < ROUTE_ENTRIES; i++)
    begin : g_cell
        irf_cell #(
            .CNT_W (CNT_W),
            .INDEX (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .count   (count_reg),
            .wr      (wr),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1])
        );
        assign tok_valids[i] = tok[i+1].valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_addr_reg <= 32'h0000_0000;
            count_reg      <= '0;
            widx_reg       <= '0;
            sum_reg        <= '0;
            ttl_reg        <= 8'd0;
            dest_reg       <= 32'h0000_0000;
            busy_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                local_addr_reg <= cfg_wr_data;
            end
            if (wr.en)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (hdr_acc)
            begin
                if (s_axis_tlast)
                begin
                    widx_reg <= '0;
                    sum_reg  <= '0;
                    ttl_reg  <= 8'd0;
                    dest_reg <= 32'h0000_0000;
                end
                else
                begin
                    widx_reg <= capture ? widx_reg + WORD_IDX_W'(1) : widx_reg;
                    sum_reg  <= sum_next;
                    ttl_reg  <= ttl_next;
                    dest_reg <= dest_next;
                end
            end
            if (search_start)
            begin
                busy_reg <= 1'b1;
            end
            else if (chain_done && adv)
            begin
                busy_reg <= 1'b0;
            end
            if (imm_load || (chain_done && adv))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (search_start)
        begin
            pend_ttl_reg <= ttl_next - 8'd1;
            pend_ck_reg  <= ck_final;
        end
        if (imm_load)
        begin
            out_data_reg <= {5'd0, 16'h0000, 8'd0, 32'h0000_0000, imm_verdict};
        end
        else if (chain_done && adv)
        begin
            if (tok[ROUTE_ENTRIES].found)
            begin
                out_data_reg <= {5'd0, pend_ck_reg, pend_ttl_reg,
                                 tok[ROUTE_ENTRIES].hop, V_FORWARD};
            end
            else
            begin
                out_data_reg <= {5'd0, 16'h0000, 8'd0, 32'h0000_0000, V_NOROUTE};
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    a_one_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_valids))
        else $error("more than one lookup in the cell row");

    a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (|tok_valids) |-> busy_reg)
        else $error("lookup in flight while core is not busy");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !s_axis_tready)
        else $error("request accepted during a lookup");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("route count beyond table size");

    a_fwd_ttl: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tdata[2:0] == V_FORWARD)) |-> (m_axis_tdata[42:35] != 8'hFF))
        else $error("forwarded packet with wrapped TTL");

endmodule

// ===== tb/ipv4_route_forward_core_tb.sv =====
// Self-checking testbench for the IPv4 route/forward core.
`timescale 1ns / 1ps
module ipv4_route_forward_core_tb;
    import irf_pkg::*;

    localparam int ROUTE_SLOTS    = ROUTE_ENTRIES_DEF;
    localparam int HDR_WORD_LIMIT = MAX_HEADER_WORDS_DEF;
    localparam int SETTLE_CYCLES  = ROUTE_SLOTS + 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_ITEMS   = 1150;
    localparam int RANDOM_ROUTES  = 56;
    localparam int CYCLE_LIMIT    = 1000000;

    typedef struct packed {
        verdict_t    verdict;
        logic [31:0] hop;
        logic [7:0]  ttl;
        logic [15:0] csum;
    } fwd_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [31:0]           cfg_wr_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // route_prefix, route_prefix_len, route_gateway, header_word, zero fill
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;   // action
    logic                  s_axis_tlast;   // word_last
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // verdict, out_next_hop, out_ttl, out_checksum, zero fill
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // forwarding state as the block should hold it
    logic [31:0] tbl_prefix [0:ROUTE_SLOTS-1];
    logic [5:0]  tbl_len    [0:ROUTE_SLOTS-1];
    logic [31:0] tbl_gw     [0:ROUTE_SLOTS-1];
    int          n_routes;
    int          hdr_idx;
    logic [20:0] csum_acc;
    logic [7:0]  ttl_seen;
    logic [31:0] dest_seen;
    logic [31:0] local_addr;

    fwd_result_t verdicts_due [$];
    int          mismatches = 0;
    int          items_sent;
    int          cycles = 0;
    logic        no_idle;
    int          hold_asked;
    int          hold_taken = 0;
    int          hold_left = 0;
    int          rx_gap = 0;

    ipv4_route_forward_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int draw_gap();
        if (no_idle)
        begin
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    function automatic logic [31:0] route_mask(input logic [5:0] len);
        // shift by zero leaves all ones, so an empty mask falls out naturally
        return (len >= 6'd32) ? 32'hFFFF_FFFF : ~(32'hFFFF_FFFF >> len);
    endfunction

    function automatic void predict_request(input logic act, input logic [31:0] prefix,
                                            input logic [5:0] len, input logic [31:0] gw,
                                            input logic [31:0] word, input logic last);
        fwd_result_t r;
        logic [31:0] w;
        logic [31:0] m;
        logic [31:0] s;
        logic        hit;
        r.verdict = V_STORED;
        r.hop     = 32'd0;
        r.ttl     = 8'd0;
        r.csum    = 16'd0;
        if (act == ACT_ADD_ROUTE)
        begin
            if (n_routes >= ROUTE_SLOTS)
            begin
                r.verdict = V_FULL;
            end
            else
            begin
                tbl_prefix[n_routes] = prefix;
                tbl_len[n_routes]    = len;
                tbl_gw[n_routes]     = gw;
                n_routes++;
            end
            verdicts_due = {verdicts_due, r};
            return;
        end
        w = word;
        if (hdr_idx < HDR_WORD_LIMIT)
        begin
            if (hdr_idx == int'(TTL_WORD))
            begin
                ttl_seen = w[31:24];
                // TTL already decremented, checksum field zeroed
                w = {ttl_seen - 8'd1, w[23:16], 16'h0000};
            end
            else if (hdr_idx == int'(DEST_WORD))
            begin
                dest_seen = w;
            end
            csum_acc = csum_acc + 21'(w[31:16]) + 21'(w[15:0]);
            hdr_idx++;
        end
        if (!last)
        begin
            return;
        end
        if (ttl_seen == 8'd0)
        begin
            r.verdict = V_TTL;
        end
        else if (dest_seen == local_addr)
        begin
            r.verdict = V_LOCAL;
        end
        else
        begin
            hit = 1'b0;
            for (int i = 0; i < n_routes; i++)
            begin
                m = route_mask(tbl_len[i]);
                if (!hit && ((tbl_prefix[i] & m) == (dest_seen & m)))
                begin
                    hit   = 1'b1;
                    r.hop = tbl_gw[i];
                end
            end
            if (!hit)
            begin
                r.verdict = V_NOROUTE;
            end
            else
            begin
                s = 32'(csum_acc);
                s = 32'(s[15:0]) + 32'(s[31:16]);
                s = 32'(s[15:0]) + 32'(s[31:16]);
                r.verdict = V_FORWARD;
                r.ttl     = ttl_seen - 8'd1;
                r.csum    = ~s[15:0];
            end
        end
        verdicts_due = {verdicts_due, r};
        hdr_idx   = 0;
        csum_acc  = '0;
        ttl_seen  = 8'd0;
        dest_seen = 32'd0;
    endfunction

    function automatic void check_result(input logic [OUT_DATA_W-1:0] d);
        fwd_result_t e;
        if (verdicts_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("unexpected result %h", d);
            end
            return;
        end
        e = verdicts_due.pop_front();
        if (d[2:0] !== e.verdict || d[34:3] !== e.hop || d[42:35] !== e.ttl ||
            d[58:43] !== e.csum)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("mismatch: verdict %0d/%0d hop %h/%h ttl %0d/%0d csum %h/%h",
                         e.verdict, d[2:0], e.hop, d[34:3], e.ttl, d[42:35],
                         e.csum, d[58:43]);
            end
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            check_result(m_axis_tdata);
        end
    end

    // result side: random stalls per result, plus long hold-offs on request
    always @(posedge clk)
    begin
        if (hold_taken != hold_asked)
        begin
            hold_taken = hold_asked;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            rx_gap = draw_gap();
            m_axis_tready <= (rx_gap == 0);
        end
        else if (!m_axis_tready)
        begin
            if (rx_gap > 0)
            begin
                rx_gap = rx_gap - 1;
            end
            m_axis_tready <= (rx_gap == 0);
        end
    end

    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", verdicts_due.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_req(input logic act, input logic [31:0] prefix, input logic [5:0] len,
                            input logic [31:0] gw, input logic [31:0] word, input logic last);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, word, gw, len, prefix};
        s_axis_tuser  <= act;
        s_axis_tlast  <= last;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        predict_request(act, prefix, len, gw, word, last);
        items_sent++;
    endtask

    task automatic add_route(input logic [31:0] prefix, input logic [5:0] len,
                             input logic [31:0] gw);
        send_req(ACT_ADD_ROUTE, prefix, len, gw, $urandom(), 1'($urandom_range(0, 1)));
    endtask

    // add_at < 0: no route add inside the packet
    task automatic send_packet(input int nwords, input logic [7:0] ttl, input logic [31:0] dest,
                               input int add_at, input logic [31:0] add_prefix,
                               input logic [5:0] add_len, input logic [31:0] add_gw);
        logic [31:0] w;
        for (int k = 0; k < nwords; k++)
        begin
            if (k == add_at)
            begin
                add_route(add_prefix, add_len, add_gw);
            end
            w = $urandom();
            if (k == int'(TTL_WORD))
            begin
                w[31:24] = ttl;
            end
            if (k == int'(DEST_WORD))
            begin
                w = dest;
            end
            send_req(ACT_HDR_WORD, $urandom(), 6'($urandom_range(0, 63)), $urandom(), w,
                     k == nwords - 1);
        end
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (verdicts_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_local(input logic [31:0] addr);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= addr;
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        local_addr = addr;
    endtask

    function automatic logic [7:0] pick_ttl();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            return 8'd0;
        end
        if (r < 20)
        begin
            return 8'd1;
        end
        if (r < 25)
        begin
            return 8'hFF;
        end
        return 8'($urandom_range(2, 254));
    endfunction

    function automatic logic [5:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
        begin
            return 6'($urandom_range(33, 63));
        end
        if (r < 8)
        begin
            return 6'($urandom_range(1, 7));
        end
        return 6'($urandom_range(8, 32));
    endfunction

    // local address, a host under a stored route, or anything
    function automatic logic [31:0] pick_dest();
        int          r;
        int          i;
        logic [31:0] m;
        r = $urandom_range(0, 99);
        if (r < 25)
        begin
            return local_addr;
        end
        if (r < 75 && n_routes > 0)
        begin
            i = $urandom_range(0, n_routes - 1);
            m = route_mask(tbl_len[i]);
            return (tbl_prefix[i] & m) | ($urandom() & ~m);
        end
        return $urandom();
    endfunction

    task automatic test_empty_table();
        send_packet(5, 8'd64, 32'hC0A8_0101, -1, 32'd0, 6'd0, 32'd0);
        send_packet(3, 8'd0, 32'hC0A8_0101, -1, 32'd0, 6'd0, 32'd0);
        // TTL word never arrives
        send_packet(1, 8'd9, 32'hC0A8_0101, -1, 32'd0, 6'd0, 32'd0);
        // destination word never arrives, so it reads as zero = local
        send_packet(4, 8'd9, 32'hC0A8_0101, -1, 32'd0, 6'd0, 32'd0);
    endtask

    task automatic test_route_basics();
        add_route(32'h0A00_0001, 6'd32, 32'hFFFF_FFFF);
        add_route(32'hFFFF_FFFF, 6'd63, 32'h0000_0000);
        send_packet(5, 8'd1, 32'h0A00_0001, -1, 32'd0, 6'd0, 32'd0);
        send_packet(5, 8'hFF, 32'hFFFF_FFFF, -1, 32'd0, 6'd0, 32'd0);
        // route lands while the packet is in flight and must be used by it
        send_packet(5, 8'd128, 32'hC0A8_1234, 2, 32'hC0A8_9999, 6'd16, 32'h1234_5678);
    endtask

    task automatic test_output_stall();
        no_idle    <= 1'b1;
        hold_asked <= hold_asked + 1;
        for (int k = 0; k < 24; k++)
        begin
            send_packet(1, 8'd0, 32'd0, -1, 32'd0, 6'd0, 32'd0);
        end
        send_packet(5, 8'd77, pick_dest(), -1, 32'd0, 6'd0, 32'd0);
        no_idle <= 1'b0;
        wait_drain();
    endtask

    task automatic test_random_traffic();
        int start;
        int r;
        int nwords;
        for (int c = 0; c < 6; c++)
        begin
            wait_drain();
            case (c)
                0: write_local(32'hFFFF_FFFF);
                2: write_local(32'h0000_0000);
                default: write_local($urandom());
            endcase
            no_idle <= (c == 3);
            start = items_sent;
            while (items_sent - start < RANDOM_ITEMS / 6)
            begin
                r = $urandom_range(0, 99);
                if (r < 6 && n_routes < RANDOM_ROUTES)
                begin
                    add_route($urandom(), pick_len(), $urandom());
                end
                else if (r < 12)
                begin
                    send_packet($urandom_range(1, 4), pick_ttl(), pick_dest(), -1,
                                32'd0, 6'd0, 32'd0);
                end
                else if (r < 16)
                begin
                    // too long: words past the limit are ignored
                    send_packet($urandom_range(16, 18), pick_ttl(), pick_dest(), -1,
                                32'd0, 6'd0, 32'd0);
                end
                else
                begin
                    nwords = $urandom_range(5, 15);
                    send_packet(nwords, pick_ttl(), pick_dest(),
                                (r < 20 && n_routes < RANDOM_ROUTES) ?
                                    $urandom_range(0, 4) : -1,
                                $urandom(), pick_len(), $urandom());
                end
            end
        end
        no_idle <= 1'b0;
        wait_drain();
    endtask

    task automatic test_table_full();
        // zero-length prefix matches every destination
        add_route($urandom(), 6'd0, 32'hA5A5_5A5A);
        while (n_routes < ROUTE_SLOTS)
        begin
            add_route($urandom(), pick_len(), $urandom());
        end
        repeat (3) add_route($urandom(), pick_len(), $urandom());
        send_packet(5, 8'd200, $urandom(), 2, $urandom(), 6'd32, $urandom());
        send_packet(5, 8'd17, local_addr, -1, 32'd0, 6'd0, 32'd0);
        send_packet(6, 8'd0, $urandom(), -1, 32'd0, 6'd0, 32'd0);
        send_packet(9, 8'd2, pick_dest(), -1, 32'd0, 6'd0, 32'd0);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 32'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        n_routes      = 0;
        hdr_idx       = 0;
        csum_acc      = '0;
        ttl_seen      = 8'd0;
        dest_seen     = 32'd0;
        local_addr    = 32'd0;
        items_sent    = 0;
        no_idle       = 1'b0;
        hold_asked    = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_route_basics();
        test_output_stall();
        test_random_traffic();
        test_table_full();
        wait_drain();

        if (verdicts_due.size() != 0)
        begin
            $display("%0d results never arrived", verdicts_due.size());
        end
        if (mismatches == 0 && verdicts_due.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
